// ----- hw/rtl/q2e_pkg.sv -----
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared constants, lane types and the arctangent table of the quaternion to
// Euler angle converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int NST           = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int SQRT_STEPS    = 31;
  localparam int NORM_CELLS    = 5;
  localparam int PITCH_EXTRA   = SQRT_STEPS + 2;
  localparam int ATAN_LAT      = NST + NORM_CELLS + 4;
  localparam int LAT           = ATAN_LAT + PITCH_EXTRA + 4;

  localparam int Q_W   = 32;
  localparam int W_W   = 64;
  localparam int CX_W  = 36;
  localparam int Z_W   = 34;
  localparam int P_W   = 48;
  localparam int ANG_W = 17;

  localparam logic signed [13:0] DEG_SCALE = 14'sd5730;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sh0_6487_ED50;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007,
    32'h00000003, 32'h00000001, 32'h00000000, 32'h00000000
  };

  typedef struct packed {
    logic [W_W-1:0]        v;
    logic [W_W-1:0]        res;
    logic signed [Q_W-1:0] aux;
  } sqrt_lane_t;

  typedef struct packed {
    logic signed [W_W-1:0] x;
    logic signed [W_W-1:0] y;
    logic [W_W-1:0]        m;
    logic                  zf;
  } norm_lane_t;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   zf;
  } cordic_lane_t;

  function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] idx);
    return signed'({2'b00, ATAN_TAB[idx]});
  endfunction

endpackage

// ----- hw/rtl/q2e_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One step of the integer square root: settles one result bit per cell.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell (
  input  logic                 clk,
  input  logic                 en,
  input  logic [4:0]           step_i,
  input  q2e_pkg::sqrt_lane_t  lane_i,
  output q2e_pkg::sqrt_lane_t  lane_o
);

  logic [5:0]                  pos;
  logic [q2e_pkg::W_W-1:0]     bitv;
  logic [q2e_pkg::W_W-1:0]     trial;
  q2e_pkg::sqrt_lane_t         lane_nxt;
  q2e_pkg::sqrt_lane_t         lane_r;

  always_comb begin
    pos      = 6'd60 - {step_i, 1'b0};
    bitv     = 64'd1 << pos;
    trial    = lane_i.res + bitv;
    lane_nxt = lane_i;
    if (lane_i.v >= trial) begin
      lane_nxt.v   = lane_i.v - trial;
      lane_nxt.res = (lane_i.res >> 1) + bitv;
    end else begin
      lane_nxt.res = lane_i.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

// ----- hw/rtl/q2e_norm_cell.sv -----
// ----------------------------------------------------------------------------
// q2e_norm_cell
// One binary step of operand normalization: shifts the pair right or left by
// a fixed amount so that the larger magnitude moves toward [2^29, 2^30).
// ----------------------------------------------------------------------------
module q2e_norm_cell (
  input  logic                 clk,
  input  logic                 en,
  input  logic [4:0]           sh_i,
  input  q2e_pkg::norm_lane_t  lane_i,
  output q2e_pkg::norm_lane_t  lane_o
);

  logic [5:0]                  rpos;
  logic [5:0]                  lpos;
  logic [q2e_pkg::W_W-1:0]     rthr;
  logic [q2e_pkg::W_W-1:0]     lthr;
  q2e_pkg::norm_lane_t         lane_nxt;
  q2e_pkg::norm_lane_t         lane_r;

  always_comb begin
    rpos     = 6'd29 + {1'b0, sh_i};
    lpos     = 6'd30 - {1'b0, sh_i};
    rthr     = 64'd1 << rpos;
    lthr     = 64'd1 << lpos;
    lane_nxt = lane_i;
    if (lane_i.m >= rthr) begin
      lane_nxt.x = lane_i.x >>> sh_i;
      lane_nxt.y = lane_i.y >>> sh_i;
      lane_nxt.m = lane_i.m >> sh_i;
    end else if (!lane_i.zf && (lane_i.m < lthr)) begin
      lane_nxt.x = lane_i.x <<< sh_i;
      lane_nxt.y = lane_i.y <<< sh_i;
      lane_nxt.m = lane_i.m << sh_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

// ----- hw/rtl/q2e_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One CORDIC vectoring micro-rotation with its arctangent step.
// ----------------------------------------------------------------------------
module q2e_cordic_cell (
  input  logic                   clk,
  input  logic                   en,
  input  logic [4:0]             idx_i,
  input  q2e_pkg::cordic_lane_t  lane_i,
  output q2e_pkg::cordic_lane_t  lane_o
);

  logic signed [q2e_pkg::CX_W-1:0] dx;
  logic signed [q2e_pkg::CX_W-1:0] dy;
  logic signed [q2e_pkg::Z_W-1:0]  da;
  q2e_pkg::cordic_lane_t           lane_nxt;
  q2e_pkg::cordic_lane_t           lane_r;

  always_comb begin
    dx       = lane_i.y >>> idx_i;
    dy       = lane_i.x >>> idx_i;
    da       = q2e_pkg::atan_q30(idx_i);
    lane_nxt = lane_i;
    if (!lane_i.y[q2e_pkg::CX_W-1]) begin
      lane_nxt.x = lane_i.x + dx;
      lane_nxt.y = lane_i.y - dy;
      lane_nxt.z = lane_i.z + da;
    end else begin
      lane_nxt.x = lane_i.x - dx;
      lane_nxt.y = lane_i.y + dy;
      lane_nxt.z = lane_i.z - da;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

// ----- hw/rtl/q2e_atan.sv -----
// ----------------------------------------------------------------------------
// q2e_atan
// Pipelined atan2: magnitude, normalization cells, quadrant fold, CORDIC
// cells and scaling to rounded hundredths of a degree.
// ----------------------------------------------------------------------------
module q2e_atan (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [q2e_pkg::W_W-1:0]      y_i,
  input  logic signed [q2e_pkg::W_W-1:0]      x_i,
  output logic signed [q2e_pkg::ANG_W-1:0]    ang_o
);

  logic [q2e_pkg::W_W-1:0]               ax;
  logic [q2e_pkg::W_W-1:0]               ay;
  q2e_pkg::norm_lane_t                   n0_nxt;
  q2e_pkg::norm_lane_t                   nl [q2e_pkg::NORM_CELLS+1];
  q2e_pkg::norm_lane_t                   n0_r;
  logic signed [q2e_pkg::CX_W-1:0]       xn;
  logic signed [q2e_pkg::CX_W-1:0]       yn;
  q2e_pkg::cordic_lane_t                 c0_nxt;
  q2e_pkg::cordic_lane_t                 c0_r;
  q2e_pkg::cordic_lane_t                 cl [q2e_pkg::NST+1];
  logic signed [q2e_pkg::P_W-1:0]        prod_nxt;
  logic signed [q2e_pkg::P_W-1:0]        prod_r;
  logic signed [q2e_pkg::P_W-1:0]        rsum;
  logic signed [q2e_pkg::ANG_W-1:0]      ang_r;

  always_comb begin
    ax        = x_i[q2e_pkg::W_W-1] ? 64'(-x_i) : 64'(x_i);
    ay        = y_i[q2e_pkg::W_W-1] ? 64'(-y_i) : 64'(y_i);
    n0_nxt.x  = x_i;
    n0_nxt.y  = y_i;
    n0_nxt.m  = (ax > ay) ? ax : ay;
    n0_nxt.zf = (ax == '0) && (ay == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n0_r <= n0_nxt;
    end
  end

  assign nl[0] = n0_r;

  for (genvar g = 0; g < q2e_pkg::NORM_CELLS; g++) begin : g_norm
    q2e_norm_cell u_norm (
      .clk    (clk),
      .en     (en),
      .sh_i   (5'(1 << (q2e_pkg::NORM_CELLS - 1 - g))),
      .lane_i (nl[g]),
      .lane_o (nl[g+1])
    );
  end

  always_comb begin
    xn        = nl[q2e_pkg::NORM_CELLS].x[q2e_pkg::CX_W-1:0];
    yn        = nl[q2e_pkg::NORM_CELLS].y[q2e_pkg::CX_W-1:0];
    c0_nxt.zf = nl[q2e_pkg::NORM_CELLS].zf;
    c0_nxt.x  = xn;
    c0_nxt.y  = yn;
    c0_nxt.z  = '0;
    if (xn[q2e_pkg::CX_W-1]) begin
      if (!yn[q2e_pkg::CX_W-1]) begin
        c0_nxt.x = yn;
        c0_nxt.y = -xn;
        c0_nxt.z = q2e_pkg::HALF_PI_Q30;
      end else begin
        c0_nxt.x = -yn;
        c0_nxt.y = xn;
        c0_nxt.z = -q2e_pkg::HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0_r <= c0_nxt;
    end
  end

  assign cl[0] = c0_r;

  for (genvar g = 0; g < q2e_pkg::NST; g++) begin : g_cordic
    q2e_cordic_cell u_cordic (
      .clk    (clk),
      .en     (en),
      .idx_i  (5'(g)),
      .lane_i (cl[g]),
      .lane_o (cl[g+1])
    );
  end

  always_comb begin
    prod_nxt = cl[q2e_pkg::NST].zf ? '0 :
               48'(cl[q2e_pkg::NST].z) * 48'(q2e_pkg::DEG_SCALE);
    rsum     = prod_r + 48'sd536870912;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      ang_r  <= rsum[46:30];
    end
  end

  assign ang_o = ang_r;

endmodule

// ----- hw/rtl/quaternion_to_euler_angles_top.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top
// Converts Q30 attitude quaternions to Z-Y-X Euler angles in hundredths of a
// degree through three pipelined CORDIC atan2 units.
// ----------------------------------------------------------------------------
// The block takes one input transaction every clock cycle unless the output
// stalls. The angles come out at the end of the pitch path: ten products, the
// sums, a squaring step, a 31-cell square root chain and the atan2 unit; roll
// and yaw wait in delay lines to stay aligned. Transactions without a
// quaternion produce no output. The whole pipeline stalls only while the
// output register holds a result that is not taken.
module quaternion_to_euler_angles_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // qw, qx, qy, qz
  input  logic [0:0]   in_tuser,   // quat_present
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata   // pitch_cdeg, roll_cdeg, yaw_cdeg, zero pad
);

  localparam int LAT = q2e_pkg::LAT;
  localparam int PE  = q2e_pkg::PITCH_EXTRA;
  localparam int SS  = q2e_pkg::SQRT_STEPS;

  logic                                   adv;
  logic [LAT-1:0]                         vld_r;
  logic signed [q2e_pkg::Q_W-1:0]         q_r [4];
  logic signed [q2e_pkg::W_W-1:0]         p00_r, p01_r, p02_r, p03_r, p11_r;
  logic signed [q2e_pkg::W_W-1:0]         p12_r, p13_r, p22_r, p23_r, p33_r;
  logic signed [q2e_pkg::W_W-1:0]         s_c;
  logic signed [q2e_pkg::W_W-1:0]         s_cl;
  logic signed [q2e_pkg::W_W-1:0]         ry_r, rx_r, yy_r, yx_r;
  logic signed [q2e_pkg::Q_W-1:0]         s30_r, s30d_r, s30e_r;
  logic [q2e_pkg::W_W-1:0]                sq_r, rad_r;
  q2e_pkg::sqrt_lane_t                    sl [SS+1];
  logic signed [q2e_pkg::ANG_W-1:0]       pang, rang, yang;
  logic signed [q2e_pkg::ANG_W-1:0]       rdl_r [PE];
  logic signed [q2e_pkg::ANG_W-1:0]       ydl_r [PE];
  logic signed [14:0]                     pitch_nxt, pitch_r;
  logic signed [15:0]                     roll_nxt, roll_r, yaw_nxt, yaw_r;

  localparam logic signed [q2e_pkg::W_W-1:0] ONE_Q56 = 64'sd1 <<< 56;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid & in_tuser[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        q_r[i] <= in_tdata[i*32 +: 32];
      end
      p00_r <= q_r[0] * q_r[0];
      p01_r <= q_r[0] * q_r[1];
      p02_r <= q_r[0] * q_r[2];
      p03_r <= q_r[0] * q_r[3];
      p11_r <= q_r[1] * q_r[1];
      p12_r <= q_r[1] * q_r[2];
      p13_r <= q_r[1] * q_r[3];
      p22_r <= q_r[2] * q_r[2];
      p23_r <= q_r[2] * q_r[3];
      p33_r <= q_r[3] * q_r[3];
    end
  end

  always_comb begin
    s_c  = ((p02_r >>> 4) - (p13_r >>> 4)) <<< 1;
    s_cl = s_c;
    if (s_c > ONE_Q56) begin
      s_cl = ONE_Q56;
    end else if (s_c < -ONE_Q56) begin
      s_cl = -ONE_Q56;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s30_r  <= 32'(s_cl >>> 26);
      ry_r   <= ((p23_r >>> 4) + (p01_r >>> 4)) <<< 1;
      rx_r   <= ONE_Q56 - ((p11_r >>> 4) <<< 1) - ((p22_r >>> 4) <<< 1);
      yy_r   <= ((p12_r >>> 4) + (p03_r >>> 4)) <<< 1;
      yx_r   <= (p00_r >>> 4) + (p11_r >>> 4) - (p22_r >>> 4) - (p33_r >>> 4);
      sq_r   <= s30_r * s30_r;
      s30d_r <= s30_r;
      rad_r  <= (64'd1 << 60) - sq_r;
      s30e_r <= s30d_r;
    end
  end

  assign sl[0] = '{v: rad_r, res: '0, aux: s30e_r};

  for (genvar g = 0; g < SS; g++) begin : g_sqrt
    q2e_sqrt_cell u_sqrt (
      .clk    (clk),
      .en     (adv),
      .step_i (5'(g)),
      .lane_i (sl[g]),
      .lane_o (sl[g+1])
    );
  end

  q2e_atan u_pitch (
    .clk   (clk),
    .en    (adv),
    .y_i   (64'(sl[SS].aux)),
    .x_i   (signed'(sl[SS].res)),
    .ang_o (pang)
  );

  q2e_atan u_roll (
    .clk   (clk),
    .en    (adv),
    .y_i   (ry_r),
    .x_i   (rx_r),
    .ang_o (rang)
  );

  q2e_atan u_yaw (
    .clk   (clk),
    .en    (adv),
    .y_i   (yy_r),
    .x_i   (yx_r),
    .ang_o (yang)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      rdl_r[0] <= rang;
      ydl_r[0] <= yang;
      for (int i = 1; i < PE; i++) begin
        rdl_r[i] <= rdl_r[i-1];
        ydl_r[i] <= ydl_r[i-1];
      end
    end
  end

  always_comb begin
    pitch_nxt = 15'(pang);
    if (pang > 17'sd9001) begin
      pitch_nxt = 15'sd9001;
    end else if (pang < -17'sd9001) begin
      pitch_nxt = -15'sd9001;
    end
    roll_nxt = 16'(rdl_r[PE-1]);
    if (rdl_r[PE-1] > 17'sd18002) begin
      roll_nxt = 16'sd18002;
    end else if (rdl_r[PE-1] < -17'sd18002) begin
      roll_nxt = -16'sd18002;
    end
    yaw_nxt = 16'(ydl_r[PE-1]);
    if (ydl_r[PE-1] > 17'sd18002) begin
      yaw_nxt = 16'sd18002;
    end else if (ydl_r[PE-1] < -17'sd18002) begin
      yaw_nxt = -16'sd18002;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pitch_r <= pitch_nxt;
      roll_r  <= roll_nxt;
      yaw_r   <= yaw_nxt;
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {1'b0, yaw_r, roll_r, pitch_r};

endmodule

// ----- hw/rtl/q2e_checker.sv -----
// ----------------------------------------------------------------------------
// q2e_checker
// Port-level checks of the quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
module q2e_assertions (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [47:0]  out_tdata
);

  ap_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output transaction dropped while stalled");

  ap_hold_data : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output data changed while stalled");

  ap_pitch_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[14:0]) <= 15'sd9001) &&
                   ($signed(out_tdata[14:0]) >= -15'sd9001))
    else $error("pitch out of range");

  ap_roll_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[30:15]) <= 16'sd18002) &&
                   ($signed(out_tdata[30:15]) >= -16'sd18002))
    else $error("roll out of range");

  ap_pad_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[47])
    else $error("padding bit set");

endmodule

bind quaternion_to_euler_angles_top q2e_assertions u_q2e_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
